// ===== design/color_histogram_model_builder_defines.svh =====
// assertion macros shared by the color histogram model builder rtl
// expects clk and rst_n in the scope of each use
`ifndef COLOR_HISTOGRAM_MODEL_BUILDER_DEFINES_SVH
`define COLOR_HISTOGRAM_MODEL_BUILDER_DEFINES_SVH

// same-cycle implication
`define CHMB_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define CHMB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/chmb_pkg.sv =====
// shared types and constants for the color histogram model builder
// no dependencies
package chmb_pkg;

  localparam int NUM_BINS   = 256;
  localparam int COUNT_BITS = 16;
  localparam int BIN_W      = 8;
  localparam int KIND_W     = 2;
  localparam int LEVEL_W    = 8;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int BIN_AW     = $clog2(NUM_BINS);
  localparam int PROD_W     = COUNT_BITS + LEVEL_W;
  localparam int STEP_W     = $clog2(LEVEL_W);
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QCNT_W     = QAW + 1;

  // input item codes
  localparam logic [KIND_W-1:0] KIND_COUNT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE     = 2'd2;

  localparam logic [CFG_W-1:0] GRAY_LOW_RST  = 8'd81;
  localparam logic [CFG_W-1:0] GRAY_HIGH_RST = 8'd88;
  localparam logic [CFG_W-1:0] NOISE_RST     = 8'd20;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [LEVEL_W-1:0]    LEVEL_MAX = '1;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BIN_W-1:0] bin;
    logic             in_range;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_WR,
    ST_RD_MUL,
    ST_RD_SAT,
    ST_RD_DIV,
    ST_RD_OUT
  } state_t;

endpackage

// ===== design/chmb_front.sv =====
// front end: accepts input beats, classifies them and queues commands
// depends on chmb_pkg and the shared assertion macro header
`include "color_histogram_model_builder_defines.svh"

module chmb_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [chmb_pkg::KIND_W-1:0] in_kind,
  input  logic [chmb_pkg::BIN_W-1:0]  in_bin,
  output logic                        q_valid,
  output chmb_pkg::cmd_t              q_cmd,
  input  logic                        q_ready
);

  chmb_pkg::cmd_t                   fifo_r [chmb_pkg::QDEPTH];
  logic [chmb_pkg::QAW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [chmb_pkg::QAW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [chmb_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  chmb_pkg::cmd_t                   cmd_in;
  logic                             keep;
  logic                             push;
  logic                             pop;

  // classify: unused kind and out-of-range counts are dropped here
  always_comb begin
    cmd_in.bin      = in_bin;
    cmd_in.in_range = (32'(in_bin) < chmb_pkg::NUM_BINS);
    cmd_in.op       = chmb_pkg::OP_COUNT;
    keep            = 1'b0;
    case (in_kind)
      chmb_pkg::KIND_COUNT: begin
        keep = cmd_in.in_range;
      end
      chmb_pkg::KIND_READ: begin
        cmd_in.op = chmb_pkg::OP_READ;
        keep      = 1'b1;
      end
      chmb_pkg::KIND_CLEAR: begin
        cmd_in.op = chmb_pkg::OP_CLEAR;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = (cnt_r != chmb_pkg::QCNT_W'(chmb_pkg::QDEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = fifo_r[rd_ptr_r];
  assign pop      = q_valid && q_ready;

  always_comb begin
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    cnt_nxt    = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

  `CHMB_ASSERT_NOW(a_q_bound, 1'b1, cnt_r <= chmb_pkg::QCNT_W'(chmb_pkg::QDEPTH), "queue overfill")
  `CHMB_ASSERT_NEXT(a_q_push, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "push lost")
  `CHMB_ASSERT_NEXT(a_q_pop, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "pop lost")

endmodule

// ===== design/chmb_back.sv =====
// back end: bin count store, running peak, iterative normalizer, result register
// depends on chmb_pkg and the shared assertion macro header
`include "color_histogram_model_builder_defines.svh"

module chmb_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  chmb_pkg::cmd_t                 q_cmd,
  output logic                           q_ready,
  input  logic                           cfg_we,
  input  logic [chmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chmb_pkg::CFG_W-1:0]     cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [chmb_pkg::LEVEL_W-1:0]   out_level,
  output logic [chmb_pkg::BIN_W-1:0]     out_read_bin
);

  chmb_pkg::state_t                  state_r, state_nxt;
  chmb_pkg::cmd_t                    cmd_r, cmd_nxt;
  logic [chmb_pkg::NUM_BINS-1:0]     valid_r, valid_nxt;
  logic [chmb_pkg::COUNT_BITS-1:0]   peak_r, peak_nxt;
  logic [chmb_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic [chmb_pkg::PROD_W-1:0]       rem_r, rem_nxt;
  logic [chmb_pkg::LEVEL_W-1:0]      quo_r, quo_nxt;
  logic [chmb_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic                              zero_r, zero_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [chmb_pkg::LEVEL_W-1:0]      out_level_r, out_level_nxt;
  logic [chmb_pkg::BIN_W-1:0]        out_bin_r, out_bin_nxt;
  logic [chmb_pkg::CFG_W-1:0]        gray_low_r, gray_high_r, noise_r;

  logic [chmb_pkg::COUNT_BITS-1:0]   mem [chmb_pkg::NUM_BINS];
  logic [chmb_pkg::COUNT_BITS-1:0]   mem_q_r;
  logic                              mem_we;
  logic [chmb_pkg::BIN_AW-1:0]       rd_idx;
  logic [chmb_pkg::BIN_AW-1:0]       cur_idx;
  logic                              cur_gray;
  logic [chmb_pkg::COUNT_BITS-1:0]   c_old, c_new;
  logic                              rd_ok;
  logic [chmb_pkg::COUNT_BITS-1:0]   eff_count;
  logic [chmb_pkg::PROD_W-1:0]       peak_sh8;
  logic [chmb_pkg::PROD_W-1:0]       div_sub;

  assign rd_idx    = chmb_pkg::BIN_AW'(q_cmd.bin);
  assign cur_idx   = chmb_pkg::BIN_AW'(cmd_r.bin);
  assign cur_gray  = (cmd_r.bin >= gray_low_r) && (cmd_r.bin <= gray_high_r);
  assign c_old     = valid_r[cur_idx] ? mem_q_r : '0;
  assign c_new     = (c_old == chmb_pkg::COUNT_MAX) ? c_old : c_old + 1'b1;
  assign rd_ok     = cmd_r.in_range && valid_r[cur_idx] && !cur_gray && (peak_r != '0);
  assign eff_count = rd_ok ? mem_q_r : '0;
  assign peak_sh8  = chmb_pkg::PROD_W'(peak_r) << chmb_pkg::LEVEL_W;
  assign div_sub   = chmb_pkg::PROD_W'(peak_r) << step_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    valid_nxt     = valid_r;
    peak_nxt      = peak_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_level_nxt = out_level_r;
    out_bin_nxt   = out_bin_r;
    mem_we        = 1'b0;
    q_ready       = 1'b0;
    case (state_r)
      chmb_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_nxt = q_cmd;
          case (q_cmd.op)
            chmb_pkg::OP_COUNT: state_nxt = chmb_pkg::ST_CNT_WR;
            chmb_pkg::OP_READ:  state_nxt = chmb_pkg::ST_RD_MUL;
            chmb_pkg::OP_CLEAR: begin
              valid_nxt = '0;
              peak_nxt  = '0;
            end
            default: state_nxt = chmb_pkg::ST_IDLE;
          endcase
        end
      end
      chmb_pkg::ST_CNT_WR: begin
        // stored count arrived from the read issued at pop
        mem_we             = 1'b1;
        valid_nxt[cur_idx] = 1'b1;
        if (!cur_gray && (c_new > peak_r)) begin
          peak_nxt = c_new;
        end
        state_nxt = chmb_pkg::ST_IDLE;
      end
      chmb_pkg::ST_RD_MUL: begin
        prod_nxt  = chmb_pkg::PROD_W'(eff_count) * chmb_pkg::PROD_W'(chmb_pkg::LEVEL_MAX);
        zero_nxt  = !rd_ok;
        state_nxt = chmb_pkg::ST_RD_SAT;
      end
      chmb_pkg::ST_RD_SAT: begin
        quo_nxt  = '0;
        rem_nxt  = prod_r;
        step_nxt = chmb_pkg::STEP_W'(chmb_pkg::LEVEL_W - 1);
        if (zero_r) begin
          state_nxt = chmb_pkg::ST_RD_OUT;
        end else if (prod_r >= peak_sh8) begin
          // quotient would not fit in a level
          quo_nxt   = chmb_pkg::LEVEL_MAX;
          state_nxt = chmb_pkg::ST_RD_OUT;
        end else begin
          state_nxt = chmb_pkg::ST_RD_DIV;
        end
      end
      chmb_pkg::ST_RD_DIV: begin
        // restoring division, one quotient bit a cycle
        if (rem_r >= div_sub) begin
          rem_nxt         = rem_r - div_sub;
          quo_nxt[step_r] = 1'b1;
        end
        if (step_r == '0) begin
          state_nxt = chmb_pkg::ST_RD_OUT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      chmb_pkg::ST_RD_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = (quo_r <= noise_r) ? '0 : quo_r;
          out_bin_nxt   = cmd_r.bin;
          state_nxt     = chmb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = chmb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chmb_pkg::ST_IDLE;
      valid_r     <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
      gray_low_r  <= chmb_pkg::GRAY_LOW_RST;
      gray_high_r <= chmb_pkg::GRAY_HIGH_RST;
      noise_r     <= chmb_pkg::NOISE_RST;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          chmb_pkg::CFG_GRAY_LOW:  gray_low_r  <= cfg_data;
          chmb_pkg::CFG_GRAY_HIGH: gray_high_r <= cfg_data;
          chmb_pkg::CFG_NOISE:     noise_r     <= cfg_data;
          default:                 noise_r     <= noise_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    step_r      <= step_nxt;
    zero_r      <= zero_nxt;
    out_level_r <= out_level_nxt;
    out_bin_r   <= out_bin_nxt;
  end

  // count store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_idx] <= c_new;
    end
    mem_q_r <= mem[rd_idx];
  end

  assign out_valid    = out_valid_r;
  assign out_level    = out_level_r;
  assign out_read_bin = out_bin_r;

  `CHMB_ASSERT_NEXT(a_clear, state_r == chmb_pkg::ST_IDLE && q_valid && q_cmd.op == chmb_pkg::OP_CLEAR, peak_r == '0 && valid_r == '0, "clear left state behind")
  `CHMB_ASSERT_NOW(a_div_peak, state_r == chmb_pkg::ST_RD_DIV, peak_r != '0, "divide with zero peak")
  `CHMB_ASSERT_NOW(a_out_src, $rose(out_valid_r), $past(state_r) == chmb_pkg::ST_RD_OUT, "result without read")

endmodule

// ===== design/color_histogram_model_builder.sv =====
// a count reads the store at accept and writes back in the count state; a read runs the
// multiply, saturate, divide (one quotient bit a cycle) and output states, skipping the
// divide when the level is forced to zero or clipped to full scale; output waits for a
// free result register; a clear completes in idle; commands are taken only in idle
// a 4-entry command queue lets input beats keep arriving while the executor is busy
// reset (rst_n, synchronous): all bins invalid, peak zero, registers back to 81/88/20
module color_histogram_model_builder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [chmb_pkg::KIND_W-1:0]    in_kind,
  input  logic [chmb_pkg::BIN_W-1:0]     in_bin,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [chmb_pkg::LEVEL_W-1:0]   out_level,
  output logic [chmb_pkg::BIN_W-1:0]     out_read_bin,
  input  logic                           cfg_we,
  input  logic [chmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chmb_pkg::CFG_W-1:0]     cfg_data
);

  logic           q_valid;
  logic           q_ready;
  chmb_pkg::cmd_t q_cmd;

  chmb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .in_bin   (in_bin),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_ready  (q_ready)
  );

  chmb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_ready      (q_ready),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_level    (out_level),
    .out_read_bin (out_read_bin)
  );

endmodule

// ===== sim/color_histogram_model_builder_tb.sv =====
// self-checking bench for color_histogram_model_builder: counts, reads, clears and
// band/floor settings are checked against an in-bench histogram predictor
// depends on chmb_pkg and the color_histogram_model_builder rtl
module color_histogram_model_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [chmb_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [chmb_pkg::KIND_W-1:0] kind;
    logic [chmb_pkg::BIN_W-1:0]  bin;
  } pixel_item_t;

  typedef struct packed {
    logic [chmb_pkg::LEVEL_W-1:0] level;
    logic [chmb_pkg::BIN_W-1:0]   bin;
  } level_rec_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [chmb_pkg::KIND_W-1:0]    in_kind = chmb_pkg::KIND_COUNT;
  logic [chmb_pkg::BIN_W-1:0]     in_bin = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [chmb_pkg::LEVEL_W-1:0]   out_level;
  logic [chmb_pkg::BIN_W-1:0]     out_read_bin;
  logic                           cfg_we = 1'b0;
  logic [chmb_pkg::CFG_IDX_W-1:0] cfg_index = chmb_pkg::CFG_GRAY_LOW;
  logic [chmb_pkg::CFG_W-1:0]     cfg_data = '0;

  // predictor state
  logic [chmb_pkg::COUNT_BITS-1:0] hist_count [chmb_pkg::NUM_BINS];
  logic                            hist_seen  [chmb_pkg::NUM_BINS];
  logic [chmb_pkg::COUNT_BITS-1:0] hist_peak;
  logic [chmb_pkg::CFG_W-1:0]      gray_low;
  logic [chmb_pkg::CFG_W-1:0]      gray_high;
  logic [chmb_pkg::CFG_W-1:0]      noise_floor;

  pixel_item_t pending_items [$];
  level_rec_t  expected_levels [$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned beats_in = 0;
  int unsigned levels_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  color_histogram_model_builder i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_bin       (in_bin),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_level    (out_level),
    .out_read_bin (out_read_bin),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic in_gray_band(logic [chmb_pkg::BIN_W-1:0] b);
    return b >= gray_low && b <= gray_high;
  endfunction

  task automatic histogram_update(logic [chmb_pkg::KIND_W-1:0] kind,
                                  logic [chmb_pkg::BIN_W-1:0] b);
    logic [chmb_pkg::COUNT_BITS-1:0] c;
    logic [chmb_pkg::PROD_W-1:0]     prod;
    logic [chmb_pkg::PROD_W-1:0]     quot;
    level_rec_t                      rec;
    case (kind)
      chmb_pkg::KIND_COUNT: begin
        c = hist_seen[b] ? hist_count[b] : '0;
        if (c != chmb_pkg::COUNT_MAX) c = c + 1'b1;
        hist_count[b] = c;
        hist_seen[b]  = 1'b1;
        if (!in_gray_band(b) && c > hist_peak) hist_peak = c;
      end
      chmb_pkg::KIND_READ: begin
        rec.level = '0;
        rec.bin   = b;
        if (hist_seen[b] && !in_gray_band(b) && hist_peak != 0) begin
          prod = chmb_pkg::PROD_W'(hist_count[b]) * chmb_pkg::PROD_W'(255);
          quot = prod / chmb_pkg::PROD_W'(hist_peak);
          // band moved after counting can push the quotient past full scale
          rec.level = (quot > chmb_pkg::PROD_W'(chmb_pkg::LEVEL_MAX)) ?
                      chmb_pkg::LEVEL_MAX : quot[chmb_pkg::LEVEL_W-1:0];
          if (rec.level <= noise_floor) rec.level = '0;
        end
        expected_levels = {expected_levels, rec};
      end
      chmb_pkg::KIND_CLEAR: begin
        foreach (hist_seen[i]) hist_seen[i] = 1'b0;
        hist_peak = '0;
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch (%s): got %0d, expected %0d, cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // input side: one beat held until accepted, next one popped from the pending list
  always @(posedge clk) begin : drive_pixels
    pixel_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        histogram_update(in_kind, in_bin);
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          in_kind  <= nxt.kind;
          in_bin   <= nxt.bin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin : watch_levels
    level_rec_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          flag_mismatch("level beat with nothing pending", out_level, 0);
        end else begin
          want = expected_levels.pop_front();
          if (out_level !== want.level) flag_mismatch("level", out_level, want.level);
          if (out_read_bin !== want.bin) flag_mismatch("read_bin", out_read_bin, want.bin);
          levels_checked++;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d level beats outstanding",
               cycle_count, expected_levels.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_item(logic [chmb_pkg::KIND_W-1:0] kind, logic [chmb_pkg::BIN_W-1:0] b);
    pixel_item_t it;
    it.kind = kind;
    it.bin  = b;
    pending_items = {pending_items, it};
  endtask

  task automatic queue_random(int n, logic [chmb_pkg::BIN_W-1:0] hot_base);
    int                          r;
    logic [chmb_pkg::KIND_W-1:0] kind;
    logic [chmb_pkg::BIN_W-1:0]  b;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 56)      kind = chmb_pkg::KIND_COUNT;
      else if (r < 95) kind = chmb_pkg::KIND_READ;
      else if (r < 97) kind = chmb_pkg::KIND_CLEAR;
      else             kind = KIND_UNUSED;
      // most beats hit a small cluster so counts build up and levels spread out
      if ($urandom_range(0, 99) < 75) b = chmb_pkg::BIN_W'(hot_base + $urandom_range(0, 11));
      else                            b = chmb_pkg::BIN_W'($urandom_range(0, 255));
      queue_item(kind, b);
    end
  endtask

  // everything sent and answered, then room for trailing counts and clears to retire
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_levels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [chmb_pkg::CFG_IDX_W-1:0] idx,
                         logic [chmb_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      chmb_pkg::CFG_GRAY_LOW:  gray_low    = value;
      chmb_pkg::CFG_GRAY_HIGH: gray_high   = value;
      chmb_pkg::CFG_NOISE:     noise_floor = value;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_band(logic [chmb_pkg::CFG_W-1:0] lo, logic [chmb_pkg::CFG_W-1:0] hi,
                          logic [chmb_pkg::CFG_W-1:0] floor_val);
    set_reg(chmb_pkg::CFG_GRAY_LOW, lo);
    set_reg(chmb_pkg::CFG_GRAY_HIGH, hi);
    set_reg(chmb_pkg::CFG_NOISE, floor_val);
  endtask

  initial begin
    gray_low    = chmb_pkg::GRAY_LOW_RST;
    gray_high   = chmb_pkg::GRAY_HIGH_RST;
    noise_floor = chmb_pkg::NOISE_RST;
    hist_peak   = '0;
    foreach (hist_seen[i]) begin
      hist_seen[i]  = 1'b0;
      hist_count[i] = '0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 79;

    // write every bin once, then clear, so cleared bins hold stale data in the store that reads must ignore
    for (int b = 0; b < chmb_pkg::NUM_BINS; b++) begin
      queue_item(chmb_pkg::KIND_COUNT, chmb_pkg::BIN_W'(b));
    end
    queue_item(chmb_pkg::KIND_CLEAR, '0);

    // directed: zero peak, extremes, gray band edges, unused kind, clear
    queue_item(chmb_pkg::KIND_READ, 8'd0);
    queue_item(chmb_pkg::KIND_COUNT, 8'd0);
    queue_item(chmb_pkg::KIND_COUNT, 8'd255);
    queue_item(chmb_pkg::KIND_COUNT, 8'd255);
    repeat (3) queue_item(chmb_pkg::KIND_COUNT, 8'd85);
    queue_item(chmb_pkg::KIND_READ, 8'd255);
    queue_item(chmb_pkg::KIND_READ, 8'd0);
    queue_item(chmb_pkg::KIND_READ, 8'd85);
    queue_item(chmb_pkg::KIND_READ, 8'd81);
    queue_item(chmb_pkg::KIND_READ, 8'd88);
    queue_item(chmb_pkg::KIND_READ, 8'd89);
    queue_item(KIND_UNUSED, 8'd255);
    queue_item(chmb_pkg::KIND_CLEAR, 8'd0);
    queue_item(chmb_pkg::KIND_READ, 8'd255);
    repeat (3) queue_item(chmb_pkg::KIND_COUNT, 8'd85);
    queue_item(chmb_pkg::KIND_COUNT, 8'd10);
    wait_drained();

    // move the band off bin 85: its count now exceeds the peak and must clip
    set_reg(chmb_pkg::CFG_GRAY_LOW, 8'd200);
    set_reg(chmb_pkg::CFG_GRAY_HIGH, 8'd210);
    queue_item(chmb_pkg::KIND_READ, 8'd85);
    queue_item(chmb_pkg::KIND_READ, 8'd10);
    queue_item(chmb_pkg::KIND_READ, 8'd205);
    queue_item(chmb_pkg::KIND_CLEAR, 8'd0);
    queue_item(chmb_pkg::KIND_READ, 8'd10);
    queue_item(chmb_pkg::KIND_COUNT, 8'd10);
    queue_item(chmb_pkg::KIND_READ, 8'd10);
    wait_drained();

    set_band(8'd40, 8'd70, 8'd20);
    queue_random(60, 8'd35);
    wait_drained();

    send_idle_pct = 79;
    recv_idle_pct = 12;
    set_band(8'd0, 8'd255, 8'd0);
    queue_random(40, 8'd120);
    wait_drained();

    // low above high: nothing excluded
    set_band(8'd200, 8'd10, 8'd0);
    queue_random(50, 8'd250);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_band(8'd0, 8'd0, 8'd255);
    queue_random(30, 8'd0);
    wait_drained();

    set_band(8'd255, 8'd255, 8'd100);
    queue_random(50, 8'd244);
    wait_drained();

    $display("run covered %0d input beats, %0d level beats checked, %0d register writes",
             beats_in, levels_checked, reg_writes);
    $display("settings ranged from no exclusion to a full gray band, floor 0 to 255, with clipping");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
